@@ hw/rtl/periodic_tophat_grid_smoother_unit_assert.svh @@
// Assertion macros shared by the smoother's checker.
`ifndef PERIODIC_TOPHAT_GRID_SMOOTHER_UNIT_ASSERT_SVH
`define PERIODIC_TOPHAT_GRID_SMOOTHER_UNIT_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define PTGS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define PTGS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/ptgs_pkg.sv @@
// Types, constants and helper functions of the periodic top-hat grid smoother.
package ptgs_pkg;

  localparam int unsigned SAMPLE_W          = 32;
  localparam int unsigned INDEX_W           = 12;
  localparam int unsigned LIMIT_W           = 8;
  localparam int unsigned CRD_MAX_W         = 7;
  localparam int unsigned DIST_W            = 12;
  localparam int unsigned GRID_SIZE_DEFAULT = 16;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPLIT_X,
    ST_SPLIT_Y,
    ST_SWEEP,
    ST_DRAIN,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    op_t                        op;
    logic [INDEX_W-1:0]         cell_index;
    logic signed [SAMPLE_W-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smoothed_value;
    logic [INDEX_W-1:0]         result_index;
  } out_item_t;

  // Squared distance along one axis on a ring of n cells.
  function automatic logic [DIST_W-1:0] wrap_dist_sq(
    input logic [CRD_MAX_W-1:0] a,
    input logic [CRD_MAX_W-1:0] b,
    input logic [CRD_MAX_W-1:0] n
  );
    logic [CRD_MAX_W-1:0]   d;
    logic [CRD_MAX_W-1:0]   e;
    logic [CRD_MAX_W-1:0]   m;
    logic [2*CRD_MAX_W-1:0] prod;
    d = (a > b) ? (a - b) : (b - a);
    e = n - d;
    m = (e < d) ? e : d;
    prod = m * m;
    return prod[DIST_W-1:0];
  endfunction

endpackage

@@ hw/rtl/ptgs_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module ptgs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/ptgs_divider.sv @@
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
module ptgs_divider #(
  parameter int unsigned DIVIDEND_W = 44,
  parameter int unsigned DIVISOR_W  = 13
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]         divisor,
  output logic                         done,
  output logic signed [DIVIDEND_W-1:0] quotient
);

  localparam int unsigned STEP_W = $clog2(DIVIDEND_W + 1);

  logic                  busy;
  logic [STEP_W-1:0]     steps;
  logic [DIVIDEND_W-1:0] work;
  logic [DIVISOR_W-1:0]  rem;
  logic                  neg;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  assign trial = {rem, work[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DIVIDEND_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The dividend magnitude shifts out at the top while quotient bits enter below.
  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);
      rem  <= '0;
      neg  <= dividend[DIVIDEND_W-1];
    end else if (busy) begin
      rem  <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      work <= {work[DIVIDEND_W-2:0], fits};
    end
  end

  assign quotient = neg ? -$signed(work) : $signed(work);

endmodule

@@ hw/rtl/periodic_tophat_grid_smoother_unit.sv @@
// Periodic top-hat grid smoother: stores a cubic grid of GRID_SIZE cells per
// axis and returns, for a read item, the mean of all cells within the squared
// radius limit under periodic wrap. A write item is stored without leaving
// the idle state. A read item first splits the index into coordinates by
// repeated subtraction, then walks the grid RAM's single read port one cell
// per cycle, then waits on the bit-serial divider. The result sits in an
// output register, so a new item may be taken while it waits.
// An index beyond the grid makes a write do nothing and a read return zero.
module periodic_tophat_grid_smoother_unit #(
  parameter int unsigned GRID_SIZE = ptgs_pkg::GRID_SIZE_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  ptgs_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output ptgs_pkg::out_item_t              out_data,
  input  logic                             cfg_write_en,
  input  logic [ptgs_pkg::LIMIT_W-1:0]     cfg_write_data
);

  import ptgs_pkg::*;

  localparam int unsigned CELL_COUNT = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int unsigned PLANE      = GRID_SIZE * GRID_SIZE;
  localparam int unsigned ADDR_W     = $clog2(CELL_COUNT);
  localparam int unsigned CRD_W      = $clog2(GRID_SIZE);
  localparam int unsigned SUM_W      = SAMPLE_W + ADDR_W;
  localparam int unsigned CNT_W      = $clog2(CELL_COUNT + 1);

  state_t state, state_next;

  logic [LIMIT_W-1:0]         limit;
  logic [INDEX_W-1:0]         req_index;
  logic [ADDR_W-1:0]          rem_idx;
  logic [CRD_W-1:0]           cx, cy, cz;
  logic [CRD_W-1:0]           x, y, z;
  logic [ADDR_W-1:0]          addr;
  logic                       hit, hit_d, valid_d;
  logic [DIST_W-1:0]          dist_sum;
  logic signed [SUM_W-1:0]    sum;
  logic [CNT_W-1:0]           count;
  logic signed [SAMPLE_W-1:0] result;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic                       accept, in_range, ram_we, div_start, div_done, load_out;
  logic signed [SUM_W-1:0]    div_quot;

  assign accept   = in_valid && in_ready;
  assign in_range = 32'(in_data.cell_index) < CELL_COUNT;
  assign ram_we   = accept && (in_data.op == OP_WRITE) && in_range;
  assign load_out = (state == ST_FINISH) && (!out_valid || out_ready);

  ptgs_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (CELL_COUNT)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(in_data.cell_index)),
    .wdata (in_data.sample_value),
    .raddr (addr),
    .rdata (rd_data)
  );

  ptgs_divider #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (count),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign dist_sum = wrap_dist_sq(CRD_MAX_W'(x), CRD_MAX_W'(cx), CRD_MAX_W'(GRID_SIZE))
                  + wrap_dist_sq(CRD_MAX_W'(y), CRD_MAX_W'(cy), CRD_MAX_W'(GRID_SIZE))
                  + wrap_dist_sq(CRD_MAX_W'(z), CRD_MAX_W'(cz), CRD_MAX_W'(GRID_SIZE));
  assign hit      = dist_sum <= DIST_W'(limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_data.op == OP_READ) begin
          state_next = in_range ? ST_SPLIT_X : ST_FINISH;
        end
      end
      ST_SPLIT_X: begin
        if (rem_idx < ADDR_W'(PLANE)) begin
          state_next = ST_SPLIT_Y;
        end
      end
      ST_SPLIT_Y: begin
        if (rem_idx < ADDR_W'(GRID_SIZE)) begin
          state_next = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (addr == ADDR_W'(CELL_COUNT - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DIV_START;
      end
      ST_DIV_START: begin
        div_start  = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit     <= '0;
      valid_d   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        limit <= cfg_write_data;
      end
      valid_d <= (state == ST_SWEEP);
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_d <= hit;
    if (load_out) begin
      out_data.smoothed_value <= result;
      out_data.result_index   <= req_index;
    end
    // RAM data comes back in the cycle after the sweep counters that addressed it.
    if (valid_d && hit_d) begin
      sum   <= sum + SUM_W'(rd_data);
      count <= count + 1'b1;
    end
    case (state)
      ST_IDLE: begin
        req_index <= in_data.cell_index;
        rem_idx   <= ADDR_W'(in_data.cell_index);
        cx        <= '0;
        cy        <= '0;
        cz        <= '0;
        x         <= '0;
        y         <= '0;
        z         <= '0;
        addr      <= '0;
        sum       <= '0;
        count     <= '0;
        result    <= '0;
      end
      ST_SPLIT_X: begin
        if (rem_idx >= ADDR_W'(PLANE)) begin
          rem_idx <= rem_idx - ADDR_W'(PLANE);
          cx      <= cx + 1'b1;
        end
      end
      ST_SPLIT_Y: begin
        if (rem_idx >= ADDR_W'(GRID_SIZE)) begin
          rem_idx <= rem_idx - ADDR_W'(GRID_SIZE);
          cy      <= cy + 1'b1;
        end else begin
          cz <= rem_idx[CRD_W-1:0];
        end
      end
      ST_SWEEP: begin
        addr <= addr + 1'b1;
        if (z == CRD_W'(GRID_SIZE - 1)) begin
          z <= '0;
          if (y == CRD_W'(GRID_SIZE - 1)) begin
            y <= '0;
            x <= x + 1'b1;
          end else begin
            y <= y + 1'b1;
          end
        end else begin
          z <= z + 1'b1;
        end
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          result <= div_quot[SAMPLE_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hw/rtl/ptgs_checker.sv @@
// Port-level checker for the smoother, bound to the top level.
`include "periodic_tophat_grid_smoother_unit_assert.svh"

module ptgs_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input ptgs_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input ptgs_pkg::out_item_t out_data
);

  import ptgs_pkg::*;

  `PTGS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result item changed")
  `PTGS_ASSERT_NEXT(a_read_busy, clk, rst, in_valid && in_ready && in_data.op == OP_READ, !in_ready, "ready right after a read item")
  `PTGS_ASSERT_NEXT(a_write_quick, clk, rst, in_valid && in_ready && in_data.op == OP_WRITE, in_ready, "not ready right after a write item")
  `PTGS_ASSERT_IMPLY(a_idle_on_result, clk, rst, $rose(out_valid), in_ready, "result shown while still busy")

endmodule

bind periodic_tophat_grid_smoother_unit ptgs_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ test/ptgs_smoother_checker.sv @@
// Checker that tracks the grid, predicts each smoothed mean and compares results.
`timescale 1ns / 1ps
module ptgs_smoother_checker #(
  parameter int unsigned GRID_SIZE = ptgs_pkg::GRID_SIZE_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  ptgs_pkg::in_item_t           in_data,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  ptgs_pkg::out_item_t          out_data,
  input  logic                         cfg_write_en,
  input  logic [ptgs_pkg::LIMIT_W-1:0] cfg_write_data,
  output int                           mismatch_count,
  output int                           pending_results
);
  import ptgs_pkg::*;

  localparam int unsigned CELLS = GRID_SIZE * GRID_SIZE * GRID_SIZE;

  logic [LIMIT_W-1:0]         radius_limit;
  logic signed [SAMPLE_W-1:0] grid_copy [CELLS];
  out_item_t                  expected_means [$];

  // Squared distance along one axis, taking the shorter way around the ring.
  function automatic int unsigned ring_sq(int unsigned a, int unsigned b);
    int unsigned d;
    d = (a > b) ? a - b : b - a;
    if (GRID_SIZE - d < d) d = GRID_SIZE - d;
    return d * d;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sphere_mean(int unsigned idx);
    int unsigned cx;
    int unsigned cy;
    int unsigned cz;
    int unsigned span_sq;
    longint      sum;
    longint      hits;
    longint      mean;
    if (idx >= CELLS) return '0;
    cx = idx / (GRID_SIZE * GRID_SIZE);
    cy = (idx / GRID_SIZE) % GRID_SIZE;
    cz = idx % GRID_SIZE;
    sum = 0;
    hits = 0;
    for (int unsigned x = 0; x < GRID_SIZE; x++) begin
      for (int unsigned y = 0; y < GRID_SIZE; y++) begin
        for (int unsigned z = 0; z < GRID_SIZE; z++) begin
          span_sq = ring_sq(x, cx) + ring_sq(y, cy) + ring_sq(z, cz);
          if (span_sq <= radius_limit) begin
            sum += grid_copy[(x * GRID_SIZE + y) * GRID_SIZE + z];
            hits++;
          end
        end
      end
    end
    // The centre cell is always inside, so hits is never zero.
    mean = sum / hits;
    return mean[SAMPLE_W-1:0];
  endfunction

  task automatic note_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin : track
    out_item_t got;
    out_item_t want;
    if (rst) begin
      radius_limit = '0;
      mismatch_count = 0;
      expected_means.delete();
      foreach (grid_copy[i]) grid_copy[i] = '0;
    end else begin
      if (cfg_write_en) radius_limit = cfg_write_data;
      if (out_valid && out_ready) begin
        got = out_data;
        if (expected_means.size() == 0) begin
          note_mismatch($sformatf("unexpected result: index %0d value %0d",
                                  got.result_index, got.smoothed_value));
        end else begin
          want = expected_means.pop_front();
          if (got.smoothed_value !== want.smoothed_value ||
              got.result_index !== want.result_index) begin
            note_mismatch($sformatf(
              "result mismatch: expected index %0d value %0d, got index %0d value %0d",
              want.result_index, want.smoothed_value,
              got.result_index, got.smoothed_value));
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.op == OP_WRITE) begin
          if (in_data.cell_index < CELLS) grid_copy[in_data.cell_index] = in_data.sample_value;
        end else begin
          want.smoothed_value = sphere_mean(in_data.cell_index);
          want.result_index = in_data.cell_index;
          expected_means.push_back(want);
        end
      end
    end
    pending_results = expected_means.size();
  end

endmodule

@@ test/periodic_tophat_grid_smoother_unit_tb.sv @@
// Top of the smoother testbench: clock, reset, stimulus, idling and the verdict.
`timescale 1ns / 1ps
module periodic_tophat_grid_smoother_unit_tb;
  import ptgs_pkg::*;

  localparam int unsigned GRID_SIZE     = 16;
  localparam int unsigned CELLS         = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int unsigned HOLD_CYCLES   = 10000;
  localparam int unsigned MEAN_LATENCY  = 4400;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS   = 20;
  localparam int unsigned PHASES        = 7;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_ready;
  out_item_t          out_data;
  logic               cfg_write_en;
  logic [LIMIT_W-1:0] cfg_write_data;
  int                 mismatch_count;
  int                 pending_results;
  int                 results_taken = 0;
  int unsigned        send_idle_max = 0;
  int unsigned        recv_idle_max = 0;
  bit                 hold_request = 1'b0;

  always #6 clk = ~clk;

  periodic_tophat_grid_smoother_unit #(.GRID_SIZE(GRID_SIZE)) DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data)
  );

  ptgs_smoother_checker #(.GRID_SIZE(GRID_SIZE)) mean_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .mismatch_count (mismatch_count),
    .pending_results(pending_results)
  );

  always @(posedge clk) begin
    if (out_valid && out_ready) results_taken <= results_taken + 1;
  end

  // Result side: a random stall after each taken item, or a long hold on request.
  initial begin : result_side
    int unsigned stall_left;
    int          seen;
    stall_left = 0;
    seen = 0;
    out_ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (results_taken != seen) begin
        seen = results_taken;
        stall_left = $urandom_range(0, recv_idle_max);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_item(op_t op, int unsigned idx, logic signed [SAMPLE_W-1:0] sample);
    int unsigned gap;
    gap = $urandom_range(0, send_idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data.op <= op;
    in_data.cell_index <= idx[INDEX_W-1:0];
    in_data.sample_value <= sample;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  // Waits until every read has been answered and the last write has settled.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_radius(int unsigned limit);
    cfg_write_en <= 1'b1;
    cfg_write_data <= limit[LIMIT_W-1:0];
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] draw_sample();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return -1;
      4: return $signed($urandom_range(0, 1000)) - 500;
      default: return $urandom;
    endcase
  endfunction

  // Mostly uniform cells, with a share of corners where every axis wraps.
  function automatic int unsigned draw_cell();
    int unsigned x;
    int unsigned y;
    int unsigned z;
    case ($urandom_range(0, 5))
      0: return 0;
      1: return CELLS - 1;
      2: begin
        x = $urandom_range(0, 1) * (GRID_SIZE - 1);
        y = $urandom_range(0, 1) * (GRID_SIZE - 1);
        z = $urandom_range(0, 1) * (GRID_SIZE - 1);
        return (x * GRID_SIZE + y) * GRID_SIZE + z;
      end
      default: return $urandom_range(0, CELLS - 1);
    endcase
  endfunction

  initial begin : stimulus
    int unsigned fixed_radius [5];
    int unsigned pick;
    int unsigned sent;
    fixed_radius = '{63, 2, 192, 0, 27};
    in_valid = 1'b0;
    in_data = '0;
    cfg_write_en = 1'b0;
    cfg_write_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    set_radius(0);

    // Every cell is written before the first read; the first and last cells hold the extremes.
    send_idle_max = 4;
    for (int unsigned i = 0; i < CELLS; i++) begin
      if (i == 0) send_item(OP_WRITE, i, 32'sh7FFF_FFFF);
      else if (i == CELLS - 1) send_item(OP_WRITE, i, 32'sh8000_0000);
      else send_item(OP_WRITE, i, $urandom);
    end

    // A zero radius returns the cell itself.
    recv_idle_max = 4;
    send_item(OP_READ, 0, '0);
    send_item(OP_READ, CELLS - 1, '1);
    send_item(OP_READ, 2184, $urandom);
    send_item(OP_WRITE, 1, '0);
    send_item(OP_READ, 1, $urandom);
    drain_block();

    // The largest radius takes in the whole grid.
    set_radius(192);
    send_item(OP_READ, 0, $urandom);
    send_item(OP_WRITE, 7, -1);
    send_item(OP_READ, 7, $urandom);
    send_item(OP_READ, 2345, $urandom);
    drain_block();

    // Small spheres around edge cells reach across the wrap.
    set_radius(1);
    send_item(OP_READ, 0, $urandom);
    send_item(OP_READ, CELLS - 1, $urandom);
    send_item(OP_READ, GRID_SIZE - 1, $urandom);
    drain_block();
    set_radius(3);
    send_item(OP_READ, 2184, $urandom);
    send_item(OP_READ, (GRID_SIZE - 1) * GRID_SIZE, $urandom);
    drain_block();

    for (int unsigned p = 0; p < PHASES; p++) begin
      set_radius((p < 5) ? fixed_radius[p] : $urandom_range(3, 191));
      send_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 4;
      recv_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 4;
      sent = 0;
      if (p == 2) begin
        // Results back up behind a stalled output until the input stops taking items.
        send_idle_max = 0;
        hold_request = 1'b1;
        repeat (4) send_item(OP_READ, draw_cell(), $urandom);
        sent = 4;
      end
      while (sent < PHASE_ITEMS) begin
        case ($urandom_range(0, 3))
          0: begin
            pick = draw_cell();
            send_item(OP_WRITE, pick, draw_sample());
            send_item(OP_READ, pick, $urandom);
            sent += 2;
          end
          1: begin
            send_item(OP_WRITE, draw_cell(), draw_sample());
            sent++;
          end
          default: begin
            send_item(OP_READ, draw_cell(), $urandom);
            sent++;
          end
        endcase
      end
      drain_block();
    end

    repeat (MEAN_LATENCY) @(negedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
